[sv/lpi_pkg.sv]
package lpi_pkg;

  localparam int COEF_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_BITS      = 48;
  localparam int OUT_TDATA_W   = 2 * OUT_BITS;

  // Side-band travelling with each item through the pipeline.
  typedef struct packed {
    logic valid;
    logic parallel;  // determinant was zero
    logic xneg;      // sign of x quotient
    logic yneg;      // sign of y quotient
  } lpi_ctl_t;

endpackage

[sv/line_pair_intersection.sv]
// line_pair_intersection: crossing point of two lines a*x + b*y + c = 0.
//
// Input stream (s_*): one item holds both lines, six signed coefficients of
// COEF_BITS each. Output stream (m_*): one result item per input item,
// x and y in signed fixed point with FRAC_BITS fraction bits, truncated
// toward zero and saturated to 48 bits; m_tuser flags parallel or
// coincident lines (zero determinant), with both coordinates then zero.
//
// The pipeline has two front stages (products, then sign/magnitude
// differences), one restoring division step per quotient bit, and one output
// stage for saturation and sign. Throughput is one item per cycle while the
// receiver does not stall; the division chain is fully pipelined.
//
// The whole pipeline moves on one enable, which is high whenever the output
// register is empty or being taken. While the receiver stalls with a result
// waiting, every stage holds and s_tready is low; nothing is dropped or
// repeated. Reset clears all valid bits; the data registers are not reset.
module line_pair_intersection #(
  parameter int COEF_BITS = lpi_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = lpi_pkg::FRAC_BITS_DEF,
  localparam int IN_W = ((6 * COEF_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // first_a, first_b, first_c, second_a, second_b, second_c (low to high)
  input  logic [IN_W-1:0]                  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // cross_x [47:0], cross_y [95:48]
  output logic [lpi_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // parallel
  output logic                             m_tuser
);

  localparam int MW = 2 * COEF_BITS;
  localparam int NW = MW + FRAC_BITS;
  localparam int OB = lpi_pkg::OUT_BITS;
  localparam int QW = (NW > OB) ? NW : OB;

  logic en;

  // global advance: output register empty or draining
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [COEF_BITS-1:0] a1, b1, c1, a2, b2, c2;

  assign a1 = s_tdata[0*COEF_BITS +: COEF_BITS];
  assign b1 = s_tdata[1*COEF_BITS +: COEF_BITS];
  assign c1 = s_tdata[2*COEF_BITS +: COEF_BITS];
  assign a2 = s_tdata[3*COEF_BITS +: COEF_BITS];
  assign b2 = s_tdata[4*COEF_BITS +: COEF_BITS];
  assign c2 = s_tdata[5*COEF_BITS +: COEF_BITS];

  lpi_pkg::lpi_ctl_t front_ctl, div_ctl;
  logic [MW-1:0]     dmag, xmag, ymag;
  logic [NW-1:0]     xquot, yquot;

  lpi_front #(.COEF_BITS(COEF_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(s_tvalid),
    .a1      (a1),
    .b1      (b1),
    .c1      (c1),
    .a2      (a2),
    .b2      (b2),
    .c2      (c2),
    .ctl     (front_ctl),
    .dmag    (dmag),
    .xmag    (xmag),
    .ymag    (ymag)
  );

  lpi_divider #(.MW(MW), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .ctl_in (front_ctl),
    .dmag   (dmag),
    .xmag   (xmag),
    .ymag   (ymag),
    .ctl_out(div_ctl),
    .xquot  (xquot),
    .yquot  (yquot)
  );

  // Saturation: limit is 2^47 for a negative result, 2^47-1 otherwise.
  logic [QW-1:0] xq_ext, yq_ext, x_lim, y_lim, x_sat, y_sat;
  logic [OB-1:0] x_res, y_res;

  always_comb begin
    xq_ext = QW'(xquot);
    yq_ext = QW'(yquot);
    x_lim  = div_ctl.xneg ? (QW'(1) << (OB - 1)) : ((QW'(1) << (OB - 1)) - QW'(1));
    y_lim  = div_ctl.yneg ? (QW'(1) << (OB - 1)) : ((QW'(1) << (OB - 1)) - QW'(1));
    x_sat  = (xq_ext > x_lim) ? x_lim : xq_ext;
    y_sat  = (yq_ext > y_lim) ? y_lim : yq_ext;
    x_res  = div_ctl.xneg ? -x_sat[OB-1:0] : x_sat[OB-1:0];
    y_res  = div_ctl.yneg ? -y_sat[OB-1:0] : y_sat[OB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= div_ctl.parallel;
      m_tdata <= div_ctl.parallel ? '0 : {y_res, x_res};
    end
  end

endmodule

[sv/lpi_front.sv]
// Two stages: six products, then exact differences as sign and magnitude.
module lpi_front #(
  parameter int COEF_BITS = lpi_pkg::COEF_BITS_DEF,
  localparam int PW = 2 * COEF_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [COEF_BITS-1:0] a1,
  input  logic signed [COEF_BITS-1:0] b1,
  input  logic signed [COEF_BITS-1:0] c1,
  input  logic signed [COEF_BITS-1:0] a2,
  input  logic signed [COEF_BITS-1:0] b2,
  input  logic signed [COEF_BITS-1:0] c2,
  output lpi_pkg::lpi_ctl_t           ctl,
  output logic [PW-1:0]               dmag,
  output logic [PW-1:0]               xmag,
  output logic [PW-1:0]               ymag
);

  localparam int DW = PW + 1;

  logic               valid1;
  logic signed [PW-1:0] d_p, d_q, x_p, x_q, y_p, y_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (en) begin
      valid1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_p <= a1 * b2;
      d_q <= a2 * b1;
      x_p <= b1 * c2;
      x_q <= b2 * c1;
      y_p <= c1 * a2;
      y_q <= c2 * a1;
    end
  end

  logic signed [DW-1:0] d_pq, d_qp, x_pq, x_qp, y_pq, y_qp;
  logic                 d_neg, x_neg, y_neg;

  // both orders in parallel, pick by compare: one adder depth
  always_comb begin
    d_pq  = DW'(d_p) - DW'(d_q);
    d_qp  = DW'(d_q) - DW'(d_p);
    x_pq  = DW'(x_p) - DW'(x_q);
    x_qp  = DW'(x_q) - DW'(x_p);
    y_pq  = DW'(y_p) - DW'(y_q);
    y_qp  = DW'(y_q) - DW'(y_p);
    d_neg = d_p < d_q;
    x_neg = x_p < x_q;
    y_neg = y_p < y_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl.valid    <= valid1;
      ctl.parallel <= d_p == d_q;
      ctl.xneg     <= x_neg ^ d_neg;
      ctl.yneg     <= y_neg ^ d_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag <= d_neg ? d_qp[PW-1:0] : d_pq[PW-1:0];
      xmag <= x_neg ? x_qp[PW-1:0] : x_pq[PW-1:0];
      ymag <= y_neg ? y_qp[PW-1:0] : y_pq[PW-1:0];
    end
  end

endmodule

[sv/lpi_div_step.sv]
// One restoring division step, registered. Numerator and quotient share
// one shift register: numerator bits leave at the top, quotient bits
// enter at the bottom.
module lpi_div_step #(
  parameter int MW = 32,
  parameter int NW = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_in,
  input  logic [MW-1:0] rem_in,
  input  logic [MW-1:0] den,
  output logic [NW-1:0] num_out,
  output logic [MW-1:0] rem_out
);

  logic [MW:0] rsh, dif;
  logic        ge;

  always_comb begin
    rsh = {rem_in, num_in[NW-1]};
    dif = rsh - {1'b0, den};
    ge  = rsh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_out <= {num_in[NW-2:0], ge};
      rem_out <= ge ? dif[MW-1:0] : rsh[MW-1:0];
    end
  end

endmodule

[sv/lpi_divider.sv]
// Two lanes of NW division steps sharing one denominator pipeline.
module lpi_divider #(
  parameter int MW = 32,
  parameter int FRAC_BITS = lpi_pkg::FRAC_BITS_DEF,
  localparam int NW = MW + FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  lpi_pkg::lpi_ctl_t ctl_in,
  input  logic [MW-1:0]     dmag,
  input  logic [MW-1:0]     xmag,
  input  logic [MW-1:0]     ymag,
  output lpi_pkg::lpi_ctl_t ctl_out,
  output logic [NW-1:0]     xquot,
  output logic [NW-1:0]     yquot
);

  logic [NW-1:0]     num_x [0:NW];
  logic [NW-1:0]     num_y [0:NW];
  logic [MW-1:0]     rem_x [0:NW];
  logic [MW-1:0]     rem_y [0:NW];
  logic [MW-1:0]     den   [0:NW];
  lpi_pkg::lpi_ctl_t ctl   [0:NW];

  assign num_x[0] = NW'(xmag) << FRAC_BITS;
  assign num_y[0] = NW'(ymag) << FRAC_BITS;
  assign rem_x[0] = '0;
  assign rem_y[0] = '0;
  assign den[0]   = dmag;
  assign ctl[0]   = ctl_in;

  for (genvar i = 0; i < NW; i++) begin : g_step
    lpi_div_step #(.MW(MW), .NW(NW)) u_x (
      .clk    (clk),
      .en     (en),
      .num_in (num_x[i]),
      .rem_in (rem_x[i]),
      .den    (den[i]),
      .num_out(num_x[i+1]),
      .rem_out(rem_x[i+1])
    );

    lpi_div_step #(.MW(MW), .NW(NW)) u_y (
      .clk    (clk),
      .en     (en),
      .num_in (num_y[i]),
      .rem_in (rem_y[i]),
      .den    (den[i]),
      .num_out(num_y[i+1]),
      .rem_out(rem_y[i+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        den[i+1] <= den[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[i+1] <= '0;
      end else if (en) begin
        ctl[i+1] <= ctl[i];
      end
    end
  end

  assign ctl_out = ctl[NW];
  assign xquot   = num_x[NW];
  assign yquot   = num_y[NW];

endmodule
